@@ src/i2cm_pkg.sv @@
// Shared types, codes and constants of the I2C master byte engine.
package i2cm_pkg;

  // Width of the tick and half period counters.
  localparam int unsigned CNT_W = 16;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_REG_W = 16;

  localparam logic [CFG_REG_W-1:0] HALF_RESET = 16'd100;
  localparam logic [CFG_REG_W-1:0] TMO_RESET = 16'd250;

  // Largest count that the counters can hold, and the largest timeout.
  localparam logic [32:0] CNT_MAX = {1'b0, 32'hFFFF_FFFF} >> (32 - CNT_W);
  localparam logic [32:0] TMO_MAX = CNT_MAX - 33'd1;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Register indexes on the configuration port.
  localparam logic REG_HALF = 1'b0;
  localparam logic REG_TMO = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_WAIT  = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_STOP_A  = 4'd3,
    PH_STOP_B  = 4'd4,
    PH_WR_HIGH = 4'd5,
    PH_WR_LOW  = 4'd6,
    PH_WA_A    = 4'd7,
    PH_WA_B    = 4'd8,
    PH_WA_POLL = 4'd9,
    PH_RD_LOW  = 4'd10,
    PH_RD_HIGH = 4'd11,
    PH_ACK_A   = 4'd12,
    PH_ACK_B   = 4'd13
  } phase_t;

  // Effective timing values handed from the register block to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] tmo;
  } timing_t;

  // One result item.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       err;
  } res_t;

endpackage

@@ src/i2cm_cfg.sv @@
// Configuration registers with their APB-style port and the clipped timing values.
module i2cm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output i2cm_pkg::timing_t                   timing
);

  logic [i2cm_pkg::CFG_REG_W-1:0] half_r, half_nxt;
  logic [i2cm_pkg::CFG_REG_W-1:0] tmo_r, tmo_nxt;
  logic                           wr_en;
  logic                           reg_sel;
  logic [32:0]                    half_w;
  logic [32:0]                    tmo_w;
  logic [32:0]                    half_clip;
  logic [32:0]                    tmo_clip;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_pready = 1'b1;

  always_comb begin
    half_nxt = half_r;
    tmo_nxt  = tmo_r;
    if (wr_en) begin
      unique case (reg_sel)
        i2cm_pkg::REG_HALF: half_nxt = cfg_pwdata[i2cm_pkg::CFG_REG_W-1:0];
        i2cm_pkg::REG_TMO:  tmo_nxt  = cfg_pwdata[i2cm_pkg::CFG_REG_W-1:0];
        default:            half_nxt = half_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= i2cm_pkg::HALF_RESET;
      tmo_r  <= i2cm_pkg::TMO_RESET;
    end else begin
      half_r <= half_nxt;
      tmo_r  <= tmo_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_sel)
      i2cm_pkg::REG_HALF: cfg_prdata[i2cm_pkg::CFG_REG_W-1:0] = half_r;
      i2cm_pkg::REG_TMO:  cfg_prdata[i2cm_pkg::CFG_REG_W-1:0] = tmo_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // A zero half period acts as one; both values are clipped to the counter range.
  assign half_w = 33'(half_r);
  assign tmo_w  = 33'(tmo_r);

  always_comb begin
    if (half_w == 33'd0) begin
      half_clip = 33'd1;
    end else if (half_w > i2cm_pkg::CNT_MAX) begin
      half_clip = i2cm_pkg::CNT_MAX;
    end else begin
      half_clip = half_w;
    end
    if (tmo_w > i2cm_pkg::TMO_MAX) begin
      tmo_clip = i2cm_pkg::TMO_MAX;
    end else begin
      tmo_clip = tmo_w;
    end
  end

  assign timing.half = half_clip[i2cm_pkg::CNT_W-1:0];
  assign timing.tmo  = tmo_clip[i2cm_pkg::CNT_W-1:0];

endmodule

@@ src/i2cm_seq.sv @@
// Bus sequencer: phase, counters, shift register and line levels, advanced one tick per step.
module i2cm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [2:0]        op,
  input  logic [7:0]        tx_byte,
  input  logic              send_ack,
  input  logic              sda_in,
  input  i2cm_pkg::timing_t timing,
  output i2cm_pkg::res_t    res
);

  i2cm_pkg::phase_t             phase_r, phase_nxt;
  logic [3:0]                   bit_r, bit_nxt;
  logic [7:0]                   shift_r, shift_nxt;
  logic [i2cm_pkg::CNT_W-1:0]   tick_r, tick_nxt;
  logic [i2cm_pkg::CNT_W-1:0]   wait_r, wait_nxt;
  logic                         scl_r, scl_nxt;
  logic                         sda_r, sda_nxt;
  logic                         drv_r, drv_nxt;
  logic                         err_r, err_nxt;
  logic                         ackc_r, ackc_nxt;
  logic [7:0]                   rx_r, rx_nxt;
  logic                         done_nxt;

  logic [i2cm_pkg::CNT_W-1:0]   tick_inc;
  logic [i2cm_pkg::CNT_W-1:0]   wait_inc;
  logic [3:0]                   bit_inc;
  logic                         tick_exp;
  logic                         poll_half;
  logic                         poll_to;
  logic                         last_bit;

  assign tick_inc  = tick_r + 1'b1;
  assign wait_inc  = wait_r + 1'b1;
  assign bit_inc   = bit_r + 4'd1;
  assign tick_exp  = tick_r >= timing.half;
  assign poll_half = tick_inc >= timing.half;
  assign poll_to   = wait_inc > timing.tmo;
  assign last_bit  = bit_inc >= i2cm_pkg::BYTE_BITS;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    priority if (phase_r == i2cm_pkg::PH_IDLE) begin
      unique case (op)
        i2cm_pkg::OP_START: phase_nxt = i2cm_pkg::PH_START_A;
        i2cm_pkg::OP_STOP:  phase_nxt = i2cm_pkg::PH_STOP_A;
        i2cm_pkg::OP_WRITE: phase_nxt = i2cm_pkg::PH_WR_HIGH;
        i2cm_pkg::OP_WAIT:  phase_nxt = i2cm_pkg::PH_WA_A;
        i2cm_pkg::OP_READ:  phase_nxt = i2cm_pkg::PH_RD_LOW;
        default:            phase_nxt = i2cm_pkg::PH_IDLE;
      endcase
    end else if (phase_r == i2cm_pkg::PH_WA_POLL) begin
      if (!sda_in) begin
        phase_nxt = i2cm_pkg::PH_IDLE;
      end else if (poll_half && poll_to) begin
        phase_nxt = i2cm_pkg::PH_STOP_A;
      end
    end else if (tick_exp) begin
      unique case (phase_r)
        i2cm_pkg::PH_START_A: phase_nxt = i2cm_pkg::PH_START_B;
        i2cm_pkg::PH_STOP_A:  phase_nxt = i2cm_pkg::PH_STOP_B;
        i2cm_pkg::PH_WR_HIGH: phase_nxt = i2cm_pkg::PH_WR_LOW;
        i2cm_pkg::PH_WR_LOW:  phase_nxt = last_bit ? i2cm_pkg::PH_IDLE : i2cm_pkg::PH_WR_HIGH;
        i2cm_pkg::PH_WA_A:    phase_nxt = i2cm_pkg::PH_WA_B;
        i2cm_pkg::PH_WA_B:    phase_nxt = i2cm_pkg::PH_WA_POLL;
        i2cm_pkg::PH_RD_LOW:  phase_nxt = i2cm_pkg::PH_RD_HIGH;
        i2cm_pkg::PH_RD_HIGH: phase_nxt = last_bit ? i2cm_pkg::PH_ACK_A : i2cm_pkg::PH_RD_LOW;
        i2cm_pkg::PH_ACK_A:   phase_nxt = i2cm_pkg::PH_ACK_B;
        default:              phase_nxt = i2cm_pkg::PH_IDLE;
      endcase
    end
  end

  // Line levels, counters and data for the tick.
  always_comb begin
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    wait_nxt  = wait_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    err_nxt   = err_r;
    ackc_nxt  = ackc_r;
    rx_nxt    = rx_r;
    done_nxt  = 1'b0;
    priority if (phase_r == i2cm_pkg::PH_IDLE) begin
      unique case (op)
        i2cm_pkg::OP_START: begin
          drv_nxt  = 1'b1;
          sda_nxt  = 1'b1;
          scl_nxt  = 1'b1;
          tick_nxt = 1;
        end
        i2cm_pkg::OP_STOP: begin
          drv_nxt  = 1'b1;
          scl_nxt  = 1'b0;
          sda_nxt  = 1'b0;
          tick_nxt = 1;
        end
        i2cm_pkg::OP_WRITE: begin
          shift_nxt = tx_byte;
          bit_nxt   = 4'd0;
          drv_nxt   = 1'b1;
          sda_nxt   = tx_byte[7];
          scl_nxt   = 1'b1;
          tick_nxt  = 1;
        end
        i2cm_pkg::OP_WAIT: begin
          err_nxt  = 1'b0;
          drv_nxt  = 1'b0;
          sda_nxt  = 1'b1;
          tick_nxt = 1;
        end
        i2cm_pkg::OP_READ: begin
          shift_nxt = 8'd0;
          bit_nxt   = 4'd0;
          ackc_nxt  = send_ack;
          drv_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b0;
          tick_nxt  = 1;
        end
        default: begin
          done_nxt = 1'b0;
        end
      endcase
    end else if (phase_r == i2cm_pkg::PH_WA_POLL) begin
      if (!sda_in) begin
        scl_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else if (poll_half) begin
        tick_nxt = '0;
        wait_nxt = wait_inc;
        if (poll_to) begin
          err_nxt  = 1'b1;
          drv_nxt  = 1'b1;
          scl_nxt  = 1'b0;
          sda_nxt  = 1'b0;
          tick_nxt = 1;
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end else if (!tick_exp) begin
      tick_nxt = tick_inc;
    end else begin
      unique case (phase_r)
        i2cm_pkg::PH_START_A: begin
          sda_nxt  = 1'b0;
          tick_nxt = 1;
        end
        i2cm_pkg::PH_STOP_A: begin
          scl_nxt  = 1'b1;
          sda_nxt  = 1'b1;
          tick_nxt = 1;
        end
        i2cm_pkg::PH_WR_HIGH: begin
          scl_nxt  = 1'b0;
          tick_nxt = 1;
        end
        i2cm_pkg::PH_WR_LOW: begin
          bit_nxt = bit_inc;
          if (last_bit) begin
            done_nxt = 1'b1;
          end else begin
            shift_nxt = {shift_r[6:0], 1'b0};
            sda_nxt   = shift_r[6];
            scl_nxt   = 1'b1;
            tick_nxt  = 1;
          end
        end
        i2cm_pkg::PH_WA_A: begin
          scl_nxt  = 1'b1;
          tick_nxt = 1;
        end
        i2cm_pkg::PH_WA_B: begin
          tick_nxt = '0;
          wait_nxt = '0;
        end
        i2cm_pkg::PH_RD_LOW: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], sda_in};
          tick_nxt  = 1;
        end
        i2cm_pkg::PH_RD_HIGH: begin
          bit_nxt  = bit_inc;
          scl_nxt  = 1'b0;
          tick_nxt = 1;
          if (last_bit) begin
            rx_nxt  = shift_r;
            drv_nxt = 1'b1;
            sda_nxt = !ackc_r;
          end
        end
        i2cm_pkg::PH_ACK_A: begin
          scl_nxt  = 1'b1;
          tick_nxt = 1;
        end
        default: begin
          // End of start, stop or answer step; start and answer leave SCL low.
          if (phase_r == i2cm_pkg::PH_START_B || phase_r == i2cm_pkg::PH_ACK_B) begin
            scl_nxt = 1'b0;
          end
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cm_pkg::PH_IDLE;
      bit_r   <= '0;
      shift_r <= '0;
      tick_r  <= '0;
      wait_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b1;
      err_r   <= 1'b0;
      ackc_r  <= 1'b0;
      rx_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      tick_r  <= tick_nxt;
      wait_r  <= wait_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      err_r   <= err_nxt;
      ackc_r  <= ackc_nxt;
      rx_r    <= rx_nxt;
    end
  end

  assign res.scl   = scl_nxt;
  assign res.sda   = sda_nxt;
  assign res.drive = drv_nxt;
  assign res.busy  = phase_nxt != i2cm_pkg::PH_IDLE;
  assign res.done  = done_nxt;
  assign res.rx    = rx_nxt;
  assign res.err   = err_nxt;

endmodule

@@ src/i2c_master_byte_engine.sv @@
// Top level of the I2C master byte engine: input register, sequencer and result register.
// A result item is valid once its tick item has passed the input register and then the
// sequencer step that loads the result register.
// Throughput: one tick item per cycle while the result side takes items; a stall on the
// result side holds both registers and raises in_stall in the same cycle.
// Reset (rst_n low at a clock edge) empties both registers, puts the sequencer in idle with
// SCL and SDA high and driven, and loads half period 100 and acknowledge timeout 250.
module i2c_master_byte_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  // Tick items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_op,
  input  logic [7:0]                      in_tx_byte,
  input  logic                            in_send_ack,
  input  logic                            in_sda_in,
  // Result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_scl_out,
  output logic                            out_sda_out,
  output logic                            out_sda_drive,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic [7:0]                      out_rx_byte,
  output logic                            out_ack_error,
  // Configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  i2cm_pkg::timing_t timing;
  i2cm_pkg::res_t    res;

  // Input register: one tick item waiting for the sequencer.
  logic       in_v_r, in_v_nxt;
  logic [2:0] op_r;
  logic [7:0] tx_r;
  logic       sack_r;
  logic       sda_r;

  // Result register.
  logic           out_v_r, out_v_nxt;
  i2cm_pkg::res_t res_r;

  logic in_take;
  logic advance;
  logic step;

  // The sequencer may step whenever the result register is free or being emptied.
  assign advance  = !out_v_r || !out_stall;
  assign step     = in_v_r && advance;
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (!in_stall) begin
      in_v_nxt = in_valid;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers carry no reset; they are only looked at while marked valid.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_op;
      tx_r   <= in_tx_byte;
      sack_r <= in_send_ack;
      sda_r  <= in_sda_in;
    end
    if (step) begin
      res_r <= res;
    end
  end

  i2cm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .timing      (timing)
  );

  i2cm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .op       (op_r),
    .tx_byte  (tx_r),
    .send_ack (sack_r),
    .sda_in   (sda_r),
    .timing   (timing),
    .res      (res)
  );

  assign out_valid     = out_v_r;
  assign out_scl_out   = res_r.scl;
  assign out_sda_out   = res_r.sda;
  assign out_sda_drive = res_r.drive;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_rx_byte   = res_r.rx;
  assign out_ack_error = res_r.err;

  // A completing tick never reports the command as still in progress.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(res_r.busy && res_r.done))
    else $error("result shows done and busy together");

  // SDA is only ever released with its level left high.
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (res_r.drive || res_r.sda))
    else $error("SDA released with a low level");

  // A held result register keeps the sequencer from stepping.
  a_hold_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |-> !step)
    else $error("sequencer stepped while the result was held");

  // The input side only stalls while an item waits in the input register.
  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with no item waiting");

endmodule

@@ tb/sv/i2c_master_byte_engine_tb.sv @@
// Self-checking testbench of the I2C master byte engine with a cycle-exact sequencer model.
`timescale 1ns / 100ps

module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  // Rough number of random tick items, spread over four idling modes with two settings each.
  localparam int unsigned RAND_ITEMS = 1650;

  // The two op codes that the block must treat like a no-op.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // Largest count the sequencer counters can hold.
  localparam longint unsigned CNT_TOP = (64'd1 << CNT_W) - 64'd1;

  // One tick item as the testbench sees it.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx;
    logic       sack;
    logic       sda;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_op;
  logic [7:0]  in_tx_byte;
  logic        in_send_ack;
  logic        in_sda_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_sda_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_rx_byte;
  logic        out_ack_error;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  i2c_master_byte_engine u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_tx_byte   (in_tx_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_in    (in_sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_sda_drive(out_sda_drive),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_rx_byte  (out_rx_byte),
    .out_ack_error(out_ack_error),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  // 12 ns clock period.
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Sequencer model. It holds its own copy of the timing registers and of every piece of
  // state, and is advanced once for each tick item that the block accepts.
  // ---------------------------------------------------------------------------------------
  logic [CFG_REG_W-1:0] half_reg = HALF_RESET;
  logic [CFG_REG_W-1:0] tmo_reg  = TMO_RESET;

  phase_t          seq_phase = PH_IDLE;
  logic [3:0]      bit_cnt   = '0;
  logic [7:0]      shift_q   = '0;
  longint unsigned tick_cnt  = 0;
  longint unsigned hold_cnt  = 0;
  logic            lvl_scl   = 1'b1;
  logic            lvl_sda   = 1'b1;
  logic            lvl_drive = 1'b1;
  logic            err_flag  = 1'b0;
  logic            ack_sel   = 1'b0;
  logic [7:0]      rx_last   = '0;

  // Line and status reports still owed by the block, oldest first.
  res_t pending_status[$];

  // Bookkeeping for the closing summary.
  int unsigned ticks_sent = 0;
  int unsigned cmd_count[8];
  int unsigned busy_ignored = 0;
  int unsigned timeouts = 0;
  int unsigned errors = 0;

  // Idling controls: percentage of cycles with the sender idle and the receiver stalling.
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic void enter_step(phase_t p);
    seq_phase = p;
    tick_cnt = 1;
  endfunction

  // Advance the model by one tick and return the report the block should give for it.
  function automatic res_t advance_sequencer(tick_t t);
    longint unsigned h;
    longint unsigned lim;
    logic done;
    res_t r;
    // A zero half period behaves as one tick; both values are clipped to the counter width,
    // the timeout to one less than the largest count.
    h = (half_reg == '0) ? 1 : half_reg;
    if (h > CNT_TOP) h = CNT_TOP;
    lim = tmo_reg;
    if (lim > CNT_TOP - 1) lim = CNT_TOP - 1;
    done = 1'b0;
    if (seq_phase == PH_IDLE) begin
      cmd_count[t.op]++;
      case (t.op)
        OP_START: begin
          lvl_drive = 1'b1; lvl_sda = 1'b1; lvl_scl = 1'b1;
          enter_step(PH_START_A);
        end
        OP_STOP: begin
          lvl_drive = 1'b1; lvl_scl = 1'b0; lvl_sda = 1'b0;
          enter_step(PH_STOP_A);
        end
        OP_WRITE: begin
          shift_q = t.tx; bit_cnt = '0;
          lvl_drive = 1'b1; lvl_sda = shift_q[7]; lvl_scl = 1'b1;
          enter_step(PH_WR_HIGH);
        end
        OP_WAIT: begin
          // Starting a wait for the acknowledge clears an earlier failure.
          err_flag = 1'b0;
          lvl_drive = 1'b0; lvl_sda = 1'b1;
          enter_step(PH_WA_A);
        end
        OP_READ: begin
          shift_q = '0; bit_cnt = '0; ack_sel = t.sack;
          lvl_drive = 1'b0; lvl_sda = 1'b1; lvl_scl = 1'b0;
          enter_step(PH_RD_LOW);
        end
        default: ;
      endcase
    end else begin
      if (t.op inside {OP_START, OP_STOP, OP_WRITE, OP_WAIT, OP_READ}) busy_ignored++;
      if (seq_phase == PH_WA_POLL) begin
        if (!t.sda) begin
          lvl_scl = 1'b0;
          seq_phase = PH_IDLE;
          done = 1'b1;
        end else begin
          tick_cnt++;
          if (tick_cnt >= h) begin
            tick_cnt = 0;
            hold_cnt++;
            // SDA stayed high too long: flag the failure and run a full stop.
            if (hold_cnt > lim) begin
              err_flag = 1'b1;
              lvl_drive = 1'b1; lvl_scl = 1'b0; lvl_sda = 1'b0;
              enter_step(PH_STOP_A);
              timeouts++;
            end
          end
        end
      end else if (tick_cnt < h) begin
        tick_cnt++;
      end else begin
        case (seq_phase)
          PH_START_A: begin
            lvl_sda = 1'b0;
            enter_step(PH_START_B);
          end
          PH_STOP_A: begin
            lvl_scl = 1'b1; lvl_sda = 1'b1;
            enter_step(PH_STOP_B);
          end
          PH_WR_HIGH: begin
            lvl_scl = 1'b0;
            enter_step(PH_WR_LOW);
          end
          PH_WR_LOW: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= BYTE_BITS) begin
              seq_phase = PH_IDLE;
              done = 1'b1;
            end else begin
              shift_q = shift_q << 1;
              lvl_sda = shift_q[7]; lvl_scl = 1'b1;
              enter_step(PH_WR_HIGH);
            end
          end
          PH_WA_A: begin
            lvl_scl = 1'b1;
            enter_step(PH_WA_B);
          end
          PH_WA_B: begin
            seq_phase = PH_WA_POLL;
            tick_cnt = 0;
            hold_cnt = 0;
          end
          PH_RD_LOW: begin
            // SDA is sampled on the tick that raises SCL.
            lvl_scl = 1'b1;
            shift_q = {shift_q[6:0], t.sda};
            enter_step(PH_RD_HIGH);
          end
          PH_RD_HIGH: begin
            bit_cnt = bit_cnt + 4'd1;
            lvl_scl = 1'b0;
            if (bit_cnt >= BYTE_BITS) begin
              rx_last = shift_q;
              lvl_drive = 1'b1; lvl_sda = ~ack_sel;
              enter_step(PH_ACK_A);
            end else begin
              enter_step(PH_RD_LOW);
            end
          end
          PH_ACK_A: begin
            lvl_scl = 1'b1;
            enter_step(PH_ACK_B);
          end
          default: begin
            // The last step of start, stop and the answer bit ends the command.
            if (seq_phase == PH_START_B || seq_phase == PH_ACK_B) lvl_scl = 1'b0;
            seq_phase = PH_IDLE;
            done = 1'b1;
          end
        endcase
      end
    end
    r.scl   = lvl_scl;
    r.sda   = lvl_sda;
    r.drive = lvl_drive;
    r.busy  = (seq_phase != PH_IDLE);
    r.done  = done;
    r.rx    = rx_last;
    r.err   = err_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side: a random stall, and a checker that compares every accepted report with the
  // oldest one the model has predicted. Values are read at the clock edge, before any update
  // of that edge, so they are the ones the handshake really used.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected, got scl %0b sda %0b busy %0b",
                 $time, out_scl_out, out_sda_out, out_busy_res);
      end else begin
        want = pending_status.pop_front();
        check_field("scl_out", want.scl, out_scl_out);
        check_field("sda_out", want.sda, out_sda_out);
        check_field("sda_drive", want.drive, out_sda_drive);
        check_field("busy_res", want.busy, out_busy_res);
        check_field("done_res", want.done, out_done_res);
        check_field("rx_byte", want.rx, out_rx_byte);
        check_field("ack_error", want.err, out_ack_error);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------------------

  // Send one tick item, with a random idle gap in front of it, and record the report it is
  // owed once the block has accepted it. Valid is left high so that a following item can go
  // out without a gap.
  task automatic send_tick(tick_t t);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    in_op       <= t.op;
    in_tx_byte  <= t.tx;
    in_send_ack <= t.sack;
    in_sda_in   <= t.sda;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    pending_status.push_back(advance_sequencer(t));
  endtask

  // Hold the sender off until every owed report has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  // One APB transfer: optionally a write, always followed by a read that must return the
  // value. A write and its read-back go back to back, and the bus then idles.
  task automatic cfg_access(logic idx, logic do_write, logic [CFG_REG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    if (do_write) begin
      cfg_pwrite <= 1'b1;
      cfg_pwdata <= CFG_DATA_W'(value);
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      if (idx == REG_HALF) half_reg = value;
      else tmo_reg = value;
      cfg_penable <= 1'b0;
    end
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(value)) begin
      errors++;
      $display("%0t: register %0d read expected %0h, got %0h", $time, idx, value, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Timing registers change only with the bus idle and nothing left in flight.
  task automatic set_timing(logic [CFG_REG_W-1:0] half, logic [CFG_REG_W-1:0] tmo);
    drain_results();
    cfg_access(REG_HALF, 1'b1, half);
    cfg_access(REG_TMO, 1'b1, tmo);
  endtask

  // Issue one command and keep ticking until the model says it has finished. While the
  // command runs, SDA plays the part of the slave: during a read it presents slave_byte MSB
  // first, and during the acknowledge poll it stays high for ack_hold ticks before pulling
  // low. Elsewhere it is random. With noise_pct, busy ticks carry random commands that the
  // block has to ignore.
  task automatic run_command(logic [2:0] op, logic [7:0] tx, logic sack, logic [7:0] slave_byte,
                             int unsigned ack_hold, int noise_pct);
    int unsigned polls;
    tick_t t;
    polls = 0;
    t.op = op;
    t.tx = tx;
    t.sack = sack;
    t.sda = 1'($urandom_range(1));
    send_tick(t);
    while (seq_phase != PH_IDLE) begin
      t.op = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : OP_NONE;
      t.tx = 8'($urandom);
      t.sack = 1'($urandom_range(1));
      if (seq_phase == PH_WA_POLL) begin
        t.sda = (polls >= ack_hold) ? 1'b0 : 1'b1;
        polls++;
      end else if (seq_phase == PH_RD_LOW) begin
        t.sda = slave_byte[3'd7 - bit_cnt[2:0]];
      end else begin
        t.sda = 1'($urandom_range(1));
      end
      send_tick(t);
    end
  endtask

  // How long the slave keeps SDA high before it acknowledges: now and then long enough for
  // the timeout under the current settings.
  function automatic int unsigned pick_ack_hold();
    return $urandom_range(0, (int'(tmo_reg) + 2) * (int'(half_reg) + 1));
  endfunction

  // A well-formed transfer: start, an address byte and its acknowledge, one to three data
  // bytes written or read, and a stop.
  task automatic random_transfer();
    int n;
    n = $urandom_range(1, 3);
    run_command(OP_START, 8'($urandom), 1'b0, 8'h00, 0, 10);
    run_command(OP_WRITE, 8'($urandom), 1'b0, 8'h00, 0, 10);
    run_command(OP_WAIT, 8'($urandom), 1'b0, 8'h00, pick_ack_hold(), 10);
    repeat (n) begin
      if ($urandom_range(1)) begin
        run_command(OP_WRITE, 8'($urandom), 1'b0, 8'h00, 0, 10);
        run_command(OP_WAIT, 8'($urandom), 1'b0, 8'h00, pick_ack_hold(), 10);
      end else begin
        run_command(OP_READ, 8'($urandom), 1'($urandom_range(1)), 8'($urandom), 0, 10);
      end
    end
    run_command(OP_STOP, 8'($urandom), 1'b0, 8'h00, 0, 10);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Registers read back their reset values, and a start and a stop run at the default timing.
  task automatic test_reset_state();
    cfg_access(REG_HALF, 1'b0, HALF_RESET);
    cfg_access(REG_TMO, 1'b0, TMO_RESET);
    repeat (3) run_command(OP_NONE, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 0, 0);
  endtask

  // Every command with the byte extremes, acknowledges with and without a delay, and reads
  // answered with both ACK and NACK.
  task automatic test_bus_commands();
    set_timing(16'd1, 16'd3);
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_WRITE, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_WRITE, 8'hFF, 1'b1, 8'h00, 0, 0);
    run_command(OP_WAIT, 8'hFF, 1'b1, 8'h00, 2, 0);
    run_command(OP_WRITE, 8'hA5, 1'b0, 8'h00, 0, 0);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 1, 0);
    run_command(OP_READ, 8'h00, 1'b1, 8'hA5, 0, 0);
    run_command(OP_READ, 8'hFF, 1'b0, 8'h5A, 0, 0);
    run_command(OP_READ, 8'h00, 1'b1, 8'hFF, 0, 0);
    run_command(OP_READ, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 0, 0);
  endtask

  // The two spare op codes are ignored, and so is every command that turns up while busy.
  task automatic test_ignored_commands();
    set_timing(16'd2, 16'd1);
    run_command(OP_SPARE_A, 8'hFF, 1'b1, 8'h00, 0, 0);
    run_command(OP_SPARE_B, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 0, 100);
    run_command(OP_WRITE, 8'h3C, 1'b0, 8'h00, 0, 100);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 0, 100);
    run_command(OP_READ, 8'h00, 1'b1, 8'hC3, 0, 100);
    run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 0, 100);
  endtask

  // A zero half period acts as one tick, and a zero timeout fails after the first high half
  // period. A failed wait runs a stop and sets the error, which the next wait clears.
  task automatic test_zero_settings();
    set_timing(16'd0, 16'd0);
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_WRITE, 8'h81, 1'b0, 8'h00, 0, 0);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 10, 0);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 0, 0);
    set_timing(16'd3, 16'd2);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 100, 0);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 5, 0);
  endtask

  // The largest half period, then the largest timeout, which the block clips to one below
  // the counter's top count, so a slave that never answers still ends in a failure.
  task automatic test_counter_extremes();
    set_timing(16'hFFFF, 16'd2);
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 0, 0);
    set_timing(16'd1, 16'hFFFF);
    run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 0, 0);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 100000, 0);
    run_command(OP_WAIT, 8'h00, 1'b0, 8'h00, 3, 0);
  endtask

  // Random traffic under one idling mode and two random short timings. Most of it is
  // well-formed transfers; the rest is stray commands. Now and then the sender waits for
  // every owed report before it goes on.
  task automatic test_random_traffic(int send_idle, int recv_stall);
    int unsigned stop_at;
    drain_results();
    idle_pct = send_idle;
    stall_pct = recv_stall;
    repeat (2) begin
      set_timing(16'($urandom_range(3)), 16'($urandom_range(4)));
      stop_at = ticks_sent + RAND_ITEMS / 8;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(9) < 7) begin
          random_transfer();
        end else begin
          run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                      8'($urandom), pick_ack_hold(), 20);
        end
        if ($urandom_range(9) == 0) drain_results();
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_op       <= OP_NONE;
    in_tx_byte  <= 8'h00;
    in_send_ack <= 1'b0;
    in_sda_in   <= 1'b1;
    out_stall   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_bus_commands();
    test_ignored_commands();
    test_zero_settings();
    test_counter_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(83, 0);
    test_random_traffic(0, 83);
    test_random_traffic(8, 8);

    // Let the last reports come back, then leave room for anything stray.
    drain_results();
    repeat (4) @(posedge clk);

    $display("Ran %0d tick items: %0d starts, %0d stops, %0d writes, %0d reads, %0d waits",
             ticks_sent, cmd_count[OP_START], cmd_count[OP_STOP], cmd_count[OP_WRITE],
             cmd_count[OP_READ], cmd_count[OP_WAIT]);
    $display("with %0d acknowledge timeouts, %0d spare op codes and %0d commands sent while busy",
             timeouts, cmd_count[OP_SPARE_A] + cmd_count[OP_SPARE_B], busy_ignored);
    if (errors == 0) begin
      $display("i2c_master_byte_engine test passed");
    end else begin
      $display("i2c_master_byte_engine test failed");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run needs.
  initial begin
    #60_000_000;
    $display("i2c_master_byte_engine test failed");
    $finish;
  end

endmodule

@@ files.f @@
src/i2cm_pkg.sv
src/i2cm_cfg.sv
src/i2cm_seq.sv
src/i2c_master_byte_engine.sv
tb/sv/i2c_master_byte_engine_tb.sv
